/* sv/sacc_pkg.sv */
// Package with shared types and constants of the stepper axis centering controller.
package sacc_pkg;

	localparam int TICK_W = 27;
	localparam int RATE_W = 16;
	localparam int VAL_W = 16;
	localparam int TSTEP_W = 20;
	localparam int TTOTAL_W = 21;

	typedef enum logic [2:0] {
		ACT_TICK = 3'd0,
		ACT_LEFT = 3'd1,
		ACT_RIGHT = 3'd2,
		ACT_RATE = 3'd3,
		ACT_GO = 3'd4,
		ACT_STOP = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		CFG_TICK_RATE = 2'd0,
		CFG_SEARCH_RATE = 2'd1,
		CFG_CENTER_RATE = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic start;
		logic [TICK_W-1:0] dividend;
		logic [RATE_W-1:0] divisor;
	} div_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [TICK_W-1:0] quotient;
	} div_sts_t;

endpackage

/* sv/sacc_divider.sv */
// Restoring divider computing the move period one quotient bit per cycle.
module sacc_divider (
	input logic clk,
	input logic arst_n,
	input sacc_pkg::div_cmd_t cmd,
	output sacc_pkg::div_sts_t sts
);
	localparam int QW = sacc_pkg::TICK_W;
	localparam int CW = $clog2(QW + 1);

	logic [QW-1:0] quo_q;
	logic [sacc_pkg::RATE_W-1:0] rem_q;
	logic [sacc_pkg::RATE_W-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [sacc_pkg::RATE_W:0] trial;
	logic [sacc_pkg::RATE_W:0] shifted;

	assign shifted = {rem_q, quo_q[QW-1]};
	assign trial = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= cmd.dividend;
			rem_q <= '0;
			dvs_q <= (cmd.divisor == '0) ? sacc_pkg::RATE_W'(1) : cmd.divisor;
		end else if (busy_q) begin
			if (!trial[sacc_pkg::RATE_W]) begin
				rem_q <= trial[sacc_pkg::RATE_W-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[sacc_pkg::RATE_W-1:0];
				quo_q <= {quo_q[QW-2:0], 1'b0};
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign sts.quotient = quo_q;
endmodule

/* sv/sacc_datapath.sv */
// Datapath holding the move queue, counters, centering totals and result register.
module sacc_datapath #(
	parameter int QUEUE_DEPTH = 2,
	parameter int STEP_COUNT_BITS = 20
) (
	input logic clk,
	input logic arst_n,
	input logic in_acc,
	input logic [2:0] action,
	input logic [sacc_pkg::VAL_W-1:0] value,
	input logic left_limit,
	input logic right_limit,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data,
	output logic go_div,
	output logic res_load,
	output logic step_pulse_d,
	output logic direction_d,
	output logic moving_d,
	output logic centering_d,
	output logic move_done_d,
	output logic command_dropped_d,
	output logic paused_d,
	output logic [1:0] queue_level_d
);
	localparam int QW = $clog2(QUEUE_DEPTH + 1);
	localparam int QI = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam logic [2:0] PH_WAIT = 3'd0, PH_SEEK = 3'd1, PH_TRAV = 3'd2,
		PH_CPEND = 3'd3, PH_CMOVE = 3'd4, PH_DONE = 3'd5;

	sacc_pkg::div_cmd_t dcmd;
	sacc_pkg::div_sts_t dsts;

	logic [sacc_pkg::TICK_W-1:0] tick_rate_q;
	logic [sacc_pkg::RATE_W-1:0] search_rate_q, center_rate_q, user_rate_q;
	logic [sacc_pkg::TICK_W-1:0] period_q, tick_cnt_q;
	logic [STEP_COUNT_BITS-1:0] steps_q;
	logic dir_q, active_q, hold_q;
	logic [2:0] phase_q;
	logic [1:0] runs_q;
	logic [sacc_pkg::TSTEP_W-1:0] tsteps_q;
	logic [sacc_pkg::TTOTAL_W-1:0] ttotal_q;
	logic [17:0] queue_q [QUEUE_DEPTH];
	logic [QW-1:0] fill_q;

	logic [sacc_pkg::TICK_W-1:0] tick_inc;
	logic [sacc_pkg::TSTEP_W-1:0] ts_inc;
	logic [sacc_pkg::TTOTAL_W:0] tot_sum;
	logic [1:0] qkind;
	logic [15:0] qval;

	assign qkind = queue_q[0][17:16];
	assign qval = queue_q[0][15:0];
	assign tick_inc = tick_cnt_q + 1'b1;
	assign ts_inc = (tsteps_q == '1) ? tsteps_q : tsteps_q + 1'b1;
	assign tot_sum = {1'b0, ttotal_q} + (sacc_pkg::TTOTAL_W + 1)'(ts_inc);

	always_comb begin
		go_div = 1'b0;
		dcmd.divisor = search_rate_q;
		if (in_acc && action == sacc_pkg::ACT_TICK && !active_q) begin
			case (phase_q)
				PH_SEEK: go_div = !(left_limit || right_limit);
				PH_TRAV: go_div = 1'b1;
				PH_CPEND: begin
					go_div = 1'b1;
					dcmd.divisor = center_rate_q;
				end
				PH_DONE: begin
					go_div = !hold_q && fill_q != '0;
					dcmd.divisor = ({1'b0, qkind} == sacc_pkg::ACT_RATE) ? qval : user_rate_q;
				end
				default: go_div = 1'b0;
			endcase
		end
		dcmd.start = go_div;
		dcmd.dividend = tick_rate_q;
	end

	sacc_divider u_div (.clk(clk), .arst_n(arst_n), .cmd(dcmd), .sts(dsts));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= 27'd72000000;
			search_rate_q <= 16'd400;
			center_rate_q <= 16'd1000;
			user_rate_q <= 16'd400;
			period_q <= '0;
			tick_cnt_q <= '0;
			steps_q <= '0;
			dir_q <= 1'b0;
			active_q <= 1'b0;
			hold_q <= 1'b1;
			phase_q <= PH_WAIT;
			runs_q <= '0;
			tsteps_q <= '0;
			ttotal_q <= '0;
			fill_q <= '0;
			res_load <= 1'b0;
			step_pulse_d <= 1'b0;
			move_done_d <= 1'b0;
			command_dropped_d <= 1'b0;
		end else begin
			res_load <= 1'b0;
			if (dsts.done) period_q <= dsts.quotient;
			if (cfg_we) begin
				case (cfg_index)
					sacc_pkg::CFG_TICK_RATE: tick_rate_q <= cfg_data[sacc_pkg::TICK_W-1:0];
					sacc_pkg::CFG_SEARCH_RATE: search_rate_q <= cfg_data[15:0];
					sacc_pkg::CFG_CENTER_RATE: center_rate_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				res_load <= !go_div;
				step_pulse_d <= 1'b0;
				move_done_d <= 1'b0;
				command_dropped_d <= 1'b0;
				case (action)
					sacc_pkg::ACT_LEFT, sacc_pkg::ACT_RIGHT, sacc_pkg::ACT_RATE: begin
						if (fill_q < QW'(QUEUE_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							command_dropped_d <= 1'b1;
						end
					end
					sacc_pkg::ACT_GO: hold_q <= 1'b0;
					sacc_pkg::ACT_STOP: hold_q <= 1'b1;
					sacc_pkg::ACT_TICK: begin
						if (active_q) begin
							if (tick_inc >= period_q) begin
								tick_cnt_q <= '0;
								if (steps_q == '0 ||
									(phase_q == PH_DONE && left_limit && right_limit)) begin
									steps_q <= '0;
									active_q <= 1'b0;
									move_done_d <= 1'b1;
									if (phase_q == PH_TRAV) begin
										tsteps_q <= ts_inc;
										if ((left_limit && dir_q) || (right_limit && !dir_q)) begin
											dir_q <= !dir_q;
											ttotal_q <= tot_sum[sacc_pkg::TTOTAL_W] ? '1 :
												tot_sum[sacc_pkg::TTOTAL_W-1:0];
											tsteps_q <= '0;
											runs_q <= runs_q + 1'b1;
											if (runs_q + 2'd1 >= 2'd2) phase_q <= PH_CPEND;
										end
									end else if (phase_q == PH_CMOVE) begin
										phase_q <= PH_DONE;
									end
								end else begin
									steps_q <= steps_q - 1'b1;
									step_pulse_d <= 1'b1;
								end
							end else begin
								tick_cnt_q <= tick_inc;
							end
						end else begin
							case (phase_q)
								PH_WAIT: if (!left_limit && !right_limit) phase_q <= PH_SEEK;
								PH_SEEK: if (left_limit || right_limit) begin
									dir_q <= !dir_q;
									phase_q <= PH_TRAV;
								end
								default: ;
							endcase
							if (go_div) begin
								tick_cnt_q <= '0;
								active_q <= 1'b1;
								case (phase_q)
									PH_CPEND: begin
										steps_q <= STEP_COUNT_BITS'(ttotal_q >> 2);
										phase_q <= PH_CMOVE;
									end
									PH_DONE: begin
										steps_q <= STEP_COUNT_BITS'(qval);
										if ({1'b0, qkind} == sacc_pkg::ACT_RATE) user_rate_q <= qval;
										dir_q <= ({1'b0, qkind} == sacc_pkg::ACT_LEFT);
										fill_q <= fill_q - 1'b1;
									end
									default: steps_q <= STEP_COUNT_BITS'(1);
								endcase
							end
						end
					end
					default: ;
				endcase
			end
			if (dsts.done) res_load <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (go_div && phase_q == PH_DONE) begin
				for (int i = 0; i + 1 < QUEUE_DEPTH; i++) queue_q[i] <= queue_q[i + 1];
			end
			if ((action == sacc_pkg::ACT_LEFT || action == sacc_pkg::ACT_RIGHT ||
				action == sacc_pkg::ACT_RATE) && fill_q < QW'(QUEUE_DEPTH))
				queue_q[QI'(fill_q)] <= {action[1:0], value};
		end
	end

	assign direction_d = dir_q;
	assign moving_d = active_q;
	assign centering_d = (phase_q != PH_DONE);
	assign paused_d = hold_q;
	assign queue_level_d = 2'(fill_q);
endmodule

/* sv/sacc_ctrl.sv */
// Controller for the input and result handshakes around the datapath.
module sacc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic div_go,
	input logic res_load,
	input logic out_stall,
	output logic in_stall,
	output logic out_valid
);
	typedef enum logic [1:0] {S_IDLE, S_DIV, S_FULL} state_t;
	state_t state_q;

	assign in_stall = (state_q != S_IDLE) && !(state_q == S_FULL && !out_stall);
	assign out_valid = (state_q == S_FULL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= div_go ? S_DIV : S_FULL;
				S_DIV: if (res_load) state_q <= S_FULL;
				S_FULL: if (!out_stall) state_q <= in_valid ? (div_go ? S_DIV : S_FULL) : S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* sv/stepper_axis_controller_centering_top.sv */
// Top level of the single-axis stepper step generator with self-centering.
// Input items (action, value, limit switches) use valid and stall; each accepted
// item gives one result item on the output channel, also with valid and stall.
// A result appears in the cycle after its item if the item starts no move. Items that
// start a move wait while the shared restoring divider computes the period,
// one quotient bit per cycle; in that time input is stalled.
// Otherwise one item is taken per cycle while results are taken as fast.
// When the receiver stalls, the held result stays and input stalls as well.
// Configuration writes use cfg_valid and cfg_ready with cfg_index and cfg_data;
// write them only while the block is idle.
// Reset puts the block into its centering sequence, paused with an empty queue.
module stepper_axis_controller_centering_top #(
	parameter int QUEUE_DEPTH = 2,
	parameter int STEP_COUNT_BITS = 20
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [2:0] action,
	input logic [15:0] value,
	input logic left_limit,
	input logic right_limit,
	output logic out_valid,
	input logic out_stall,
	output logic step_pulse,
	output logic direction,
	output logic moving,
	output logic centering,
	output logic move_done,
	output logic command_dropped,
	output logic paused,
	output logic [1:0] queue_level,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [31:0] cfg_data
);
	logic in_acc, go_div, res_load;
	logic sp, dr, mv, ce, md, cd, pa;
	logic [1:0] ql;

	assign in_acc = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	sacc_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .STEP_COUNT_BITS(STEP_COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_acc(in_acc), .action(action), .value(value),
		.left_limit(left_limit), .right_limit(right_limit),
		.cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.go_div(go_div), .res_load(res_load), .step_pulse_d(sp),
		.direction_d(dr), .moving_d(mv), .centering_d(ce), .move_done_d(md),
		.command_dropped_d(cd), .paused_d(pa), .queue_level_d(ql));

	sacc_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .div_go(go_div),
		.res_load(res_load), .out_stall(out_stall), .in_stall(in_stall),
		.out_valid(out_valid));

	assign step_pulse = sp;
	assign direction = dr;
	assign moving = mv;
	assign centering = ce;
	assign move_done = md;
	assign command_dropped = cd;
	assign paused = pa;
	assign queue_level = ql;

`ifndef SYNTHESIS
	a_pulse_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(step_pulse && move_done)) else $error("pulse and done together");
	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> queue_level <= 2'(QUEUE_DEPTH)) else $error("queue level too high");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result lost under stall");
`endif
endmodule
